FILE: sv/pcs_pkg.sv
`default_nettype none
// ============================================================================
// pcs_pkg: shared types and constants for the PID step unit
// Widths, register indexes, reset values, sequencer states and the command
// that the sequencer sends to the shared multiply-accumulate unit.
// ============================================================================
package pcs_pkg;

    localparam int DATA_W      = 32;   // Q16.16 ports and gains
    localparam int ERR_W       = 33;   // target - measured
    localparam int DIFF_W      = 34;   // error - last error
    localparam int ACCUM_W     = 48;   // Q32.16 integral
    localparam int QUO_W       = 50;   // derivative magnitude
    localparam int MAG_W       = 64;   // multiplicand, padded to whole chunks
    localparam int CHUNK_W     = 16;   // multiplicand bits per MAC beat
    localparam int CHUNK_IDX_W = 2;
    localparam int PROD_W      = CHUNK_W + DATA_W;
    localparam int MAC_W       = 84;   // exact sum of the three products
    localparam int CFG_IDX_W   = 4;
    localparam int DIV_STEPS   = QUO_W / 2;   // two quotient bits per cycle
    localparam int DIV_CNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd3;

    localparam logic [DATA_W-1:0] GAIN_P_RESET = 32'h0000_8000;   // 0.5
    localparam logic [DATA_W-1:0] GAIN_I_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] GAIN_D_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] TARGET_RESET = 32'h0064_0000;   // 100.0

    localparam logic [ACCUM_W-1:0] ACCUM_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ACCUM_W-1:0] ACCUM_MIN = 48'h8000_0000_0000;
    localparam logic [DATA_W-1:0]  DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  DRIVE_MIN = 32'h8000_0000;

    localparam logic [CHUNK_IDX_W-1:0] CHUNK_LAST_SHORT = 2'd2;
    localparam logic [CHUNK_IDX_W-1:0] CHUNK_LAST_LONG  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_INT,
        ST_INT_WAIT,
        ST_ACC,
        ST_P,
        ST_I,
        ST_DWAIT,
        ST_D,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                   issue;
        logic                   clear;
        logic                   neg;
        logic [CHUNK_IDX_W-1:0] shift;
    } mac_cmd_t;

endpackage
`default_nettype wire

FILE: sv/pcs_div.sv
`default_nettype none
// ============================================================================
// pcs_div: radix-2 restoring divider, two quotient bits per cycle
// Unsigned dividend over a 32-bit divisor; quotient holds until next start.
// ============================================================================
module pcs_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pcs_pkg::QUO_W-1:0]   dividend,
    input  wire logic [pcs_pkg::DATA_W-1:0]  divisor,
    output logic                             busy,
    output logic                             done,
    output logic [pcs_pkg::QUO_W-1:0]        quotient
);

    logic [pcs_pkg::QUO_W-1:0]     quo_reg;
    logic [pcs_pkg::DATA_W-1:0]    rem_reg;
    logic [pcs_pkg::DATA_W-1:0]    dvs_reg;
    logic [pcs_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [pcs_pkg::DATA_W:0]      trial_a;
    logic [pcs_pkg::DATA_W:0]      sub_a;
    logic                          ge_a;
    logic [pcs_pkg::DATA_W-1:0]    rem_a;
    logic [pcs_pkg::QUO_W-1:0]     quo_a;
    logic [pcs_pkg::DATA_W:0]      trial_b;
    logic [pcs_pkg::DATA_W:0]      sub_b;
    logic                          ge_b;
    logic [pcs_pkg::DATA_W-1:0]    rem_b;
    logic [pcs_pkg::QUO_W-1:0]     quo_b;

    // The shift register carries the unused dividend bits at its top and
    // collects quotient bits at its bottom.
    always_comb
    begin
        trial_a = {rem_reg, quo_reg[pcs_pkg::QUO_W-1]};
        sub_a   = trial_a - {1'b0, dvs_reg};
        ge_a    = (trial_a >= {1'b0, dvs_reg});
        rem_a   = ge_a ? sub_a[pcs_pkg::DATA_W-1:0] : trial_a[pcs_pkg::DATA_W-1:0];
        quo_a   = {quo_reg[pcs_pkg::QUO_W-2:0], ge_a};
        trial_b = {rem_a, quo_a[pcs_pkg::QUO_W-1]};
        sub_b   = trial_b - {1'b0, dvs_reg};
        ge_b    = (trial_b >= {1'b0, dvs_reg});
        rem_b   = ge_b ? sub_b[pcs_pkg::DATA_W-1:0] : trial_b[pcs_pkg::DATA_W-1:0];
        quo_b   = {quo_a[pcs_pkg::QUO_W-2:0], ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_b;
            rem_reg <= rem_b;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: sv/pcs_mac.sv
`default_nettype none
// ============================================================================
// pcs_mac: shared 16x32 multiply-accumulate unit
// One multiplicand chunk per beat; the product is registered, then shifted
// into place and added to or subtracted from an 84-bit accumulator.
// ============================================================================
module pcs_mac (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pcs_pkg::mac_cmd_t             cmd,
    input  wire logic [pcs_pkg::CHUNK_W-1:0]   a_chunk,
    input  wire logic [pcs_pkg::DATA_W-1:0]    b,
    output logic [pcs_pkg::MAC_W-1:0]          acc
);

    pcs_pkg::mac_cmd_t                cmd1_reg;
    logic [pcs_pkg::PROD_W-1:0]       pp_reg;
    logic [pcs_pkg::MAC_W-1:0]        acc_reg;
    logic [pcs_pkg::MAC_W-1:0]        acc_next;
    logic [pcs_pkg::MAC_W-1:0]        term;
    logic [pcs_pkg::MAC_W-1:0]        base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg <= '0;
        end
        else
        begin
            cmd1_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= {{(pcs_pkg::PROD_W-pcs_pkg::CHUNK_W){1'b0}}, a_chunk}
                * {{(pcs_pkg::PROD_W-pcs_pkg::DATA_W){1'b0}}, b};
    end

    // Bits shifted past the top are dropped; the final sum always fits.
    always_comb
    begin
        term = {{(pcs_pkg::MAC_W-pcs_pkg::PROD_W){1'b0}}, pp_reg}
               << {cmd1_reg.shift, 4'b0000};
        base = cmd1_reg.clear ? '0 : acc_reg;
        if (!cmd1_reg.issue)
            acc_next = acc_reg;
        else if (cmd1_reg.neg)
            acc_next = base - term;
        else
            acc_next = base + term;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

FILE: sv/pid_controller_step_unit.sv
`default_nettype none
// An accepted input beat runs through the sequencer states in order, and its result is
// registered onto out_valid from ST_OUT once the output is free. A new input beat is
// taken only when the sequencer is back in ST_IDLE, so one item is worked on at a time.
// With a zero step_time the divider is not started; otherwise the derivative divider sets
// the pace, and the shared 16x32 multiplier runs its 13 beats partly under it. Reset (rst_n low, async)
// loads gain and target defaults, clears integral, previous error, sequencer, out_valid.
// ============================================================================
// pid_controller_step_unit: positional PID step in Q16.16 fixed point
// Sequencer around one shared multiply-accumulate unit and one divider.
// ============================================================================
module pid_controller_step_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [pcs_pkg::DATA_W-1:0]   measured,
    input  wire logic [pcs_pkg::DATA_W-1:0]          step_time,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pcs_pkg::DATA_W-1:0]        drive,
    output logic                                     clipped,
    output logic                                     zero_step,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pcs_pkg::DATA_W-1:0]          cfg_data
);

    pcs_pkg::state_t                   state_reg;
    pcs_pkg::state_t                   state_next;
    logic [pcs_pkg::CHUNK_IDX_W-1:0]   chunk_reg;
    logic [pcs_pkg::CHUNK_IDX_W-1:0]   chunk_next;
    logic [pcs_pkg::CHUNK_IDX_W-1:0]   chunk_last;

    logic [pcs_pkg::DATA_W-1:0]        gain_p_reg;
    logic [pcs_pkg::DATA_W-1:0]        gain_i_reg;
    logic [pcs_pkg::DATA_W-1:0]        gain_d_reg;
    logic [pcs_pkg::DATA_W-1:0]        target_reg;
    logic [pcs_pkg::ACCUM_W-1:0]       accum_reg;
    logic [pcs_pkg::ERR_W-1:0]         last_err_reg;

    logic [pcs_pkg::ERR_W-1:0]         err_reg;
    logic [pcs_pkg::ERR_W-1:0]         err_mag_reg;
    logic [pcs_pkg::DATA_W-1:0]        dt_reg;
    logic                              zstep_reg;
    logic                              diff_neg_reg;
    logic                              clip_reg;

    logic                              out_valid_reg;
    logic [pcs_pkg::DATA_W-1:0]        drive_reg;
    logic                              clipped_reg;
    logic                              zero_step_reg;

    logic [pcs_pkg::DIFF_W-1:0]        diff;
    logic [pcs_pkg::DIFF_W-1:0]        diff_mag;
    logic [pcs_pkg::ACCUM_W-1:0]       incr_mag;
    logic [pcs_pkg::ACCUM_W+1:0]       incr;
    logic [pcs_pkg::ACCUM_W+1:0]       accum_sum;
    logic [pcs_pkg::ACCUM_W-1:0]       accum_sat;
    logic                              accum_clip;
    logic [pcs_pkg::MAC_W-17:0]        scaled;
    logic [pcs_pkg::DATA_W-1:0]        drive_sat;
    logic                              drive_clip;
    logic                              out_free;
    logic                              accept;

    logic [pcs_pkg::DATA_W-1:0]        gp_mag;
    logic [pcs_pkg::DATA_W-1:0]        gi_mag;
    logic [pcs_pkg::DATA_W-1:0]        gd_mag;
    logic [pcs_pkg::ACCUM_W-1:0]       accum_mag;
    logic [pcs_pkg::MAG_W-1:0]         a_mag;
    logic [pcs_pkg::CHUNK_W-1:0]       a_chunk;
    logic [pcs_pkg::DATA_W-1:0]        mac_b;
    pcs_pkg::mac_cmd_t                 mac_cmd;
    logic [pcs_pkg::MAC_W-1:0]         mac_acc;

    logic                              div_start;
    logic                              div_busy;
    logic                              div_done;
    logic [pcs_pkg::QUO_W-1:0]         div_quo;

    pcs_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mac_cmd),
        .a_chunk (a_chunk),
        .b       (mac_b),
        .acc     (mac_acc)
    );

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, diff_mag[pcs_pkg::ERR_W-1:0], 16'b0}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Magnitudes of the signed operands for the unsigned multiplier.
    always_comb
    begin
        gp_mag    = gain_p_reg[pcs_pkg::DATA_W-1] ? (~gain_p_reg + 1'b1) : gain_p_reg;
        gi_mag    = gain_i_reg[pcs_pkg::DATA_W-1] ? (~gain_i_reg + 1'b1) : gain_i_reg;
        gd_mag    = gain_d_reg[pcs_pkg::DATA_W-1] ? (~gain_d_reg + 1'b1) : gain_d_reg;
        accum_mag = accum_reg[pcs_pkg::ACCUM_W-1] ? (~accum_reg + 1'b1) : accum_reg;
        diff      = {err_reg[pcs_pkg::ERR_W-1], err_reg}
                  - {last_err_reg[pcs_pkg::ERR_W-1], last_err_reg};
        diff_mag  = diff[pcs_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
    end

    // Integral update: the MAC holds |error| * step_time exactly.
    always_comb
    begin
        incr_mag  = mac_acc[63:16];
        incr      = err_reg[pcs_pkg::ERR_W-1] ? ('0 - {2'b00, incr_mag}) : {2'b00, incr_mag};
        accum_sum = {{2{accum_reg[pcs_pkg::ACCUM_W-1]}}, accum_reg} + incr;
        if ((accum_sum[pcs_pkg::ACCUM_W+1:pcs_pkg::ACCUM_W-1] == 3'b000)
            || (accum_sum[pcs_pkg::ACCUM_W+1:pcs_pkg::ACCUM_W-1] == 3'b111))
        begin
            accum_sat  = accum_sum[pcs_pkg::ACCUM_W-1:0];
            accum_clip = 1'b0;
        end
        else
        begin
            accum_sat  = accum_sum[pcs_pkg::ACCUM_W+1] ? pcs_pkg::ACCUM_MIN : pcs_pkg::ACCUM_MAX;
            accum_clip = 1'b1;
        end
    end

    // Output scaling: arithmetic shift by 16 floors, then clamp to 32 bits.
    always_comb
    begin
        scaled = mac_acc[pcs_pkg::MAC_W-1:16];
        if ((&scaled[pcs_pkg::MAC_W-17:pcs_pkg::DATA_W-1])
            || !(|scaled[pcs_pkg::MAC_W-17:pcs_pkg::DATA_W-1]))
        begin
            drive_sat  = scaled[pcs_pkg::DATA_W-1:0];
            drive_clip = 1'b0;
        end
        else
        begin
            drive_sat  = scaled[pcs_pkg::MAC_W-17] ? pcs_pkg::DRIVE_MIN : pcs_pkg::DRIVE_MAX;
            drive_clip = 1'b1;
        end
    end

    // Sequencer: next state and chunk counter.
    always_comb
    begin
        state_next = state_reg;
        chunk_last = (state_reg == pcs_pkg::ST_D) ? pcs_pkg::CHUNK_LAST_LONG
                                                  : pcs_pkg::CHUNK_LAST_SHORT;
        chunk_next = '0;
        case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pcs_pkg::ST_PREP;
            end
            pcs_pkg::ST_PREP:
            begin
                state_next = pcs_pkg::ST_INT;
            end
            pcs_pkg::ST_INT, pcs_pkg::ST_P, pcs_pkg::ST_I, pcs_pkg::ST_D:
            begin
                if (chunk_reg == chunk_last)
                begin
                    case (state_reg)
                        pcs_pkg::ST_INT: state_next = pcs_pkg::ST_INT_WAIT;
                        pcs_pkg::ST_P:   state_next = pcs_pkg::ST_I;
                        pcs_pkg::ST_I:   state_next = pcs_pkg::ST_DWAIT;
                        default:         state_next = pcs_pkg::ST_DRAIN;
                    endcase
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            pcs_pkg::ST_INT_WAIT:
            begin
                state_next = pcs_pkg::ST_ACC;
            end
            pcs_pkg::ST_ACC:
            begin
                state_next = pcs_pkg::ST_P;
            end
            pcs_pkg::ST_DWAIT:
            begin
                if (zstep_reg || div_done)
                    state_next = pcs_pkg::ST_D;
            end
            pcs_pkg::ST_DRAIN:
            begin
                state_next = pcs_pkg::ST_OUT;
            end
            pcs_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = pcs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: MAC operand selection, input stall and divider start.
    always_comb
    begin
        mac_cmd       = '0;
        mac_cmd.shift = chunk_reg;
        mac_cmd.clear = (chunk_reg == '0);
        a_mag         = '0;
        mac_b         = '0;
        in_stall      = 1'b1;
        div_start     = 1'b0;
        case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            pcs_pkg::ST_PREP:
            begin
                div_start = !zstep_reg;
            end
            pcs_pkg::ST_INT:
            begin
                mac_cmd.issue = 1'b1;
                a_mag         = {{(pcs_pkg::MAG_W-pcs_pkg::ERR_W){1'b0}}, err_mag_reg};
                mac_b         = dt_reg;
            end
            pcs_pkg::ST_P:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.neg   = err_reg[pcs_pkg::ERR_W-1] ^ gain_p_reg[pcs_pkg::DATA_W-1];
                a_mag         = {{(pcs_pkg::MAG_W-pcs_pkg::ERR_W){1'b0}}, err_mag_reg};
                mac_b         = gp_mag;
            end
            pcs_pkg::ST_I:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = 1'b0;
                mac_cmd.neg   = accum_reg[pcs_pkg::ACCUM_W-1] ^ gain_i_reg[pcs_pkg::DATA_W-1];
                a_mag         = {{(pcs_pkg::MAG_W-pcs_pkg::ACCUM_W){1'b0}}, accum_mag};
                mac_b         = gi_mag;
            end
            pcs_pkg::ST_D:
            begin
                mac_cmd.issue = 1'b1;
                mac_cmd.clear = 1'b0;
                mac_cmd.neg   = diff_neg_reg ^ gain_d_reg[pcs_pkg::DATA_W-1];
                a_mag         = zstep_reg ? '0
                              : {{(pcs_pkg::MAG_W-pcs_pkg::QUO_W){1'b0}}, div_quo};
                mac_b         = gd_mag;
            end
            default:
            begin
                mac_cmd = '0;
            end
        endcase
        a_chunk = a_mag[{chunk_reg, 4'b0000} +: pcs_pkg::CHUNK_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcs_pkg::ST_IDLE;
            chunk_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

    // Configuration registers and the controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= pcs_pkg::GAIN_P_RESET;
            gain_i_reg   <= pcs_pkg::GAIN_I_RESET;
            gain_d_reg   <= pcs_pkg::GAIN_D_RESET;
            target_reg   <= pcs_pkg::TARGET_RESET;
            accum_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pcs_pkg::REG_GAIN_P: gain_p_reg <= cfg_data;
                    pcs_pkg::REG_GAIN_I: gain_i_reg <= cfg_data;
                    pcs_pkg::REG_GAIN_D: gain_d_reg <= cfg_data;
                    pcs_pkg::REG_TARGET: target_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (state_reg == pcs_pkg::ST_PREP)
                last_err_reg <= err_reg;
            if (state_reg == pcs_pkg::ST_ACC)
                accum_reg <= accum_sat;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= {target_reg[pcs_pkg::DATA_W-1], target_reg}
                       - {measured[pcs_pkg::DATA_W-1], measured};
            dt_reg    <= step_time;
            zstep_reg <= (step_time == '0);
        end
        if (state_reg == pcs_pkg::ST_PREP)
        begin
            err_mag_reg  <= err_reg[pcs_pkg::ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
            diff_neg_reg <= diff[pcs_pkg::DIFF_W-1];
        end
        if (state_reg == pcs_pkg::ST_ACC)
            clip_reg <= accum_clip;
    end

    // Output register: a finished result waits here while the next item runs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == pcs_pkg::ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == pcs_pkg::ST_OUT) && out_free)
        begin
            drive_reg     <= drive_sat;
            clipped_reg   <= clip_reg | drive_clip;
            zero_step_reg <= zstep_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clipped   = clipped_reg;
    assign zero_step = zero_step_reg;
    assign cfg_ready = 1'b1;

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == pcs_pkg::ST_PREP))
        else $error("accepted beat did not start the sequence");

    a_deriv_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pcs_pkg::ST_D) && !zstep_reg) |-> (div_done && !div_busy))
        else $error("derivative product started before the quotient was ready");

    a_int_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcs_pkg::ST_ACC) |-> (mac_acc[pcs_pkg::MAC_W-1:64] == '0))
        else $error("integral increment product exceeds 64 bits");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pcs_pkg::ST_OUT) && out_free) |=> out_valid)
        else $error("finished result was not presented");

endmodule
`default_nettype wire
